FILE: rtl/squared_matrix_vector_accumulate_assert.svh
// Assertion macros shared by the squared matrix-vector accumulate RTL.
// No dependencies; included by the files that carry concurrent assertions.
`ifndef SQUARED_MATRIX_VECTOR_ACCUMULATE_ASSERT_SVH
`define SQUARED_MATRIX_VECTOR_ACCUMULATE_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define SMVA_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("smva assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is high.
`define SMVA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("smva assertion failed: next-cycle implication");

`endif

FILE: rtl/smva_pkg.sv
// Types and constants of the squared matrix-vector accumulate block.
// No dependencies; used by the interfaces, smva_ctrl, smva_dp and the top module.
package smva_pkg;

   localparam int ELEMENT_W   = 16;
   localparam int WEIGHT_W    = 16;
   localparam int SQ_W        = 31;
   localparam int PROD_W      = 46;
   localparam int SUM_W       = 56;
   localparam int ROW_INDEX_W = 10;
   localparam int ROWS_CFG_W  = 11;
   localparam int COLS_CFG_W  = 16;
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] REG_ROWS_IN_USE    = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] REG_COLUMNS_IN_USE = CSR_INDEX_W'(1);

   localparam logic [ROWS_CFG_W-1:0] ROWS_RESET = ROWS_CFG_W'(1024);
   localparam logic [COLS_CFG_W-1:0] COLS_RESET = COLS_CFG_W'(1);

   localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_SCALE,
      ST_COMMIT
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic square;
      logic scale;
      logic commit;
      logic first_col;
      logic last_col;
      logic last_row;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic out_free;
   } status_type;

endpackage

FILE: rtl/smva_req_if.sv
// Input channel: one matrix element with the weight of its column.
// Depends on smva_pkg.
interface smva_req_if;
   import smva_pkg::*;

   logic                        valid;
   logic                        ready;
   logic signed [ELEMENT_W-1:0] element;
   logic signed [WEIGHT_W-1:0]  weight;

   modport source (output valid, output element, output weight, input ready);
   modport sink (input valid, input element, input weight, output ready);
endinterface

FILE: rtl/smva_rsp_if.sv
// Result channel: one finished row sum with its row index and last mark.
// Depends on smva_pkg.
interface smva_rsp_if;
   import smva_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [ROW_INDEX_W-1:0]    row_index;
   logic signed [SUM_W-1:0]   sum;
   logic                      last;

   modport source (output valid, output row_index, output sum, output last, input ready);
   modport sink (input valid, input row_index, input sum, input last, output ready);
endinterface

FILE: rtl/smva_csr_if.sv
// Configuration write channel: register index and write data.
// Depends on smva_pkg.
interface smva_csr_if;
   import smva_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/smva_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module smva_ram #(
   parameter int WIDTH = 56,
   parameter int DEPTH = 1024
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: rtl/smva_ctrl.sv
// Controller: item sequencing, row and column counters, configuration registers.
// Depends on smva_pkg.
module smva_ctrl #(
   parameter int MAX_ROWS = 1024
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_ready,
   input  logic                                     csr_valid,
   output logic                                     csr_ready,
   input  logic [smva_pkg::CSR_INDEX_W-1:0]         csr_index,
   input  logic [smva_pkg::CSR_DATA_W-1:0]          csr_data,
   input  smva_pkg::status_type                     status,
   output smva_pkg::cmd_type                        cmd,
   output logic [(MAX_ROWS > 1 ? $clog2(MAX_ROWS) : 1)-1:0] row_addr
);
   import smva_pkg::*;

   localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int RCW = ($clog2(MAX_ROWS + 1) > ROWS_CFG_W) ? $clog2(MAX_ROWS + 1)
                                                             : ROWS_CFG_W;

   state_type               state_ff, state_in;
   logic [RW-1:0]           row_ff, row_in;
   logic [COLS_CFG_W-1:0]   col_ff, col_in;
   logic [ROWS_CFG_W-1:0]   rows_cfg_ff;
   logic [COLS_CFG_W-1:0]   cols_cfg_ff;
   logic [RCW-1:0]          eff_rows;
   logic [COLS_CFG_W-1:0]   eff_cols;
   logic                    last_row;
   logic                    last_col;

   // Zero rows acts as one, and a count above the memory depth is clamped to it.
   always_comb begin
      if (rows_cfg_ff == '0) begin
         eff_rows = RCW'(1);
      end else if (RCW'(rows_cfg_ff) > RCW'(MAX_ROWS)) begin
         eff_rows = RCW'(MAX_ROWS);
      end else begin
         eff_rows = RCW'(rows_cfg_ff);
      end
      eff_cols = (cols_cfg_ff == '0) ? COLS_CFG_W'(1) : cols_cfg_ff;
   end

   // A counter at or past its limit counts as on the last row or column.
   assign last_row = (RCW'(row_ff) + RCW'(1)) >= eff_rows;
   assign last_col = ((COLS_CFG_W+1)'(col_ff) + (COLS_CFG_W+1)'(1))
                     >= (COLS_CFG_W+1)'(eff_cols);

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_cfg_ff <= ROWS_RESET;
         cols_cfg_ff <= COLS_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_ROWS_IN_USE: begin
               rows_cfg_ff <= csr_data[ROWS_CFG_W-1:0];
            end
            REG_COLUMNS_IN_USE: begin
               cols_cfg_ff <= csr_data[COLS_CFG_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (!last_col || status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready     = 1'b0;
      cmd           = '0;
      cmd.first_col = (col_ff == '0);
      cmd.last_col  = last_col;
      cmd.last_row  = last_row;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_SQUARE: begin
            cmd.square = 1'b1;
         end
         ST_SCALE: begin
            cmd.scale = 1'b1;
         end
         ST_COMMIT: begin
            cmd.commit = !last_col || status.out_free;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      if (cmd.commit) begin
         if (last_row) begin
            row_in = '0;
            col_in = last_col ? '0 : col_ff + COLS_CFG_W'(1);
         end else begin
            row_in = row_ff + RW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         row_ff   <= '0;
         col_ff   <= '0;
      end else begin
         state_ff <= state_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
      end
   end

   assign row_addr = row_ff;
endmodule

FILE: rtl/smva_dp.sv
// Datapath: square and weight multipliers, saturating accumulate, row sum RAM,
// result register. Depends on smva_pkg and smva_ram.
module smva_dp #(
   parameter int MAX_ROWS = 1024
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  smva_pkg::cmd_type                        cmd,
   output smva_pkg::status_type                     status,
   input  logic [(MAX_ROWS > 1 ? $clog2(MAX_ROWS) : 1)-1:0] row_addr,
   input  logic signed [smva_pkg::ELEMENT_W-1:0]    element,
   input  logic signed [smva_pkg::WEIGHT_W-1:0]     weight,
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output logic [smva_pkg::ROW_INDEX_W-1:0]         rsp_row_index,
   output logic signed [smva_pkg::SUM_W-1:0]        rsp_sum,
   output logic                                     rsp_last
);
   import smva_pkg::*;

   logic signed [ELEMENT_W-1:0] element_ff;
   logic signed [WEIGHT_W-1:0]  weight_ff;
   logic [SQ_W-1:0]             sq_ff;
   logic signed [PROD_W-1:0]    prod_ff;
   logic signed [2*ELEMENT_W-1:0]        sq_full;
   logic signed [SQ_W+WEIGHT_W:0]        prod_full;
   logic [SUM_W-1:0]            old_sum;
   logic signed [SUM_W:0]       raw_sum;
   logic signed [SUM_W-1:0]     new_sum;
   logic                        rsp_valid_ff;
   logic [ROW_INDEX_W-1:0]      rsp_row_index_ff;
   logic signed [SUM_W-1:0]     rsp_sum_ff;
   logic                        rsp_last_ff;

   smva_ram #(
      .WIDTH(SUM_W),
      .DEPTH(MAX_ROWS)
   ) u_row_sums (
      .clock  (clock),
      .wr_en  (cmd.commit),
      .wr_addr(row_addr),
      .wr_data(new_sum),
      .rd_en  (cmd.load),
      .rd_addr(row_addr),
      .rd_data(old_sum)
   );

   // The square of a 16-bit value is never negative and fits in 31 bits.
   assign sq_full   = element_ff * element_ff;
   assign prod_full = $signed({1'b0, sq_ff}) * weight_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         element_ff <= element;
         weight_ff  <= weight;
      end
      if (cmd.square) begin
         sq_ff <= sq_full[SQ_W-1:0];
      end
      if (cmd.scale) begin
         prod_ff <= prod_full[PROD_W-1:0];
      end
   end

   // The first column overwrites the stored sum instead of adding to it.
   always_comb begin
      if (cmd.first_col) begin
         raw_sum = (SUM_W+1)'(prod_ff);
      end else begin
         raw_sum = (SUM_W+1)'($signed(old_sum)) + (SUM_W+1)'(prod_ff);
      end
      if (raw_sum > (SUM_W+1)'(SUM_MAX)) begin
         new_sum = SUM_MAX;
      end else if (raw_sum < (SUM_W+1)'(SUM_MIN)) begin
         new_sum = SUM_MIN;
      end else begin
         new_sum = raw_sum[SUM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit && cmd.last_col) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && cmd.last_col) begin
         rsp_row_index_ff <= ROW_INDEX_W'(row_addr);
         rsp_sum_ff       <= new_sum;
         rsp_last_ff      <= cmd.last_row;
      end
   end

   assign status.out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_row_index   = rsp_row_index_ff;
   assign rsp_sum         = rsp_sum_ff;
   assign rsp_last        = rsp_last_ff;
endmodule

FILE: rtl/squared_matrix_vector_accumulate.sv
// A row's result is registered when its last-column element is written back; a stalled
// rsp delays that write-back. Elements are taken one at a time, each written back before
// the next: RAM read-modify-write around two registered multipliers (square, then weight).
// Reset clears the row and column counters, the configuration (1024 rows, 1 column)
// and the result valid; the row sum RAM is not cleared, the first column overwrites it.
// Depends on smva_pkg, the channel interfaces, smva_ctrl, smva_dp and the assert macros.
`include "squared_matrix_vector_accumulate_assert.svh"

module squared_matrix_vector_accumulate #(
   parameter int MAX_ROWS = 1024
) (
   input  logic         clock,
   input  logic         reset,
   smva_req_if.sink     req_ch,
   smva_rsp_if.source   rsp_ch,
   smva_csr_if.sink     csr_ch
);
   import smva_pkg::*;

   localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

   cmd_type       cmd;
   status_type    status;
   logic [RW-1:0] row_addr;

   smva_ctrl #(
      .MAX_ROWS(MAX_ROWS)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_ch.valid),
      .req_ready(req_ch.ready),
      .csr_valid(csr_ch.valid),
      .csr_ready(csr_ch.ready),
      .csr_index(csr_ch.index),
      .csr_data (csr_ch.data),
      .status   (status),
      .cmd      (cmd),
      .row_addr (row_addr)
   );

   smva_dp #(
      .MAX_ROWS(MAX_ROWS)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .row_addr     (row_addr),
      .element      (req_ch.element),
      .weight       (req_ch.weight),
      .rsp_valid    (rsp_ch.valid),
      .rsp_ready    (rsp_ch.ready),
      .rsp_row_index(rsp_ch.row_index),
      .rsp_sum      (rsp_ch.sum),
      .rsp_last     (rsp_ch.last)
   );

   // Only one element is in flight: a transfer blocks the next one for a while.
   `SMVA_ASSERT_NEXT(a_one_in_flight, clock, reset, req_ch.valid && req_ch.ready, !req_ch.ready)
   // Writing back an element of the last column always presents a result.
   `SMVA_ASSERT_NEXT(a_emit_on_last_col, clock, reset, cmd.commit && cmd.last_col, rsp_ch.valid)
   // The row counter never leaves the accumulator RAM.
   `SMVA_ASSERT_IMPLY(a_row_in_range, clock, reset, cmd.commit, 32'(row_addr) < 32'(MAX_ROWS))

endmodule
